// ===== rtl/flfs_pkg.sv =====
`default_nettype none
package flfs_pkg;

  localparam int GRADE_FRAC_BITS = 8;
  localparam int GRADE_W   = GRADE_FRAC_BITS + 1;
  localparam int GRADE_ONE = 1 << GRADE_FRAC_BITS;

  localparam int SAMPLE_W = 10;
  localparam int BASE_W   = 8;
  localparam int ERR_W    = 11;
  localparam int DLT_W    = 12;
  localparam int V_W      = 13;
  localparam int DRIVE_W  = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam int N_SETS = 5;
  localparam int SET_W  = 3;
  localparam int ERR_HALF_W = 50;
  localparam int DLT_HALF_W = 10;
  localparam int SING_W = 6;

  // 25 rules of at most one full grade each, singletons up to 30
  localparam int DEN_W  = GRADE_FRAC_BITS + 5;
  localparam int NUM_W  = GRADE_FRAC_BITS + 11;
  localparam int PROD_W = GRADE_W + 1 + SING_W;
  localparam int MAG_W  = GRADE_FRAC_BITS + 13;
  localparam int XW     = MAG_W + 1;
  localparam int DCNT_W = $clog2(MAG_W);
  localparam int DRIVE_MAX = 255;

  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RBASE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LBASE    = 3'd4;

  typedef logic [GRADE_W-1:0] grade_t;
  typedef grade_t err_tab_t [ERR_HALF_W];
  typedef grade_t dlt_tab_t [DLT_HALF_W];

  typedef enum logic [1:0] {
    SHAPE_LEFT,
    SHAPE_MID,
    SHAPE_RIGHT
  } shape_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FUZZ,
    ST_RULE,
    ST_PREP_R,
    ST_DIV_R,
    ST_PREP_L,
    ST_DIV_L,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             load;
    logic             fuzz;
    logic             rule;
    logic [SET_W-1:0] ri;
    logic [SET_W-1:0] rj;
    logic             prep;
    logic             step;
    logic             last;
    logic             side_left;
    logic             out_load;
  } cmd_t;

  localparam logic signed [V_W-1:0] ERR_CENTRE [N_SETS] =
    '{-13'sd100, -13'sd50, 13'sd0, 13'sd50, 13'sd100};
  localparam logic signed [V_W-1:0] DLT_CENTRE [N_SETS] =
    '{-13'sd20, -13'sd10, 13'sd0, 13'sd10, 13'sd20};

  // [delta set][error set]
  localparam logic signed [SING_W-1:0] SINGLETON [N_SETS][N_SETS] = '{
    '{ 6'sd20,  6'sd10, -6'sd10, -6'sd10, -6'sd20},
    '{-6'sd20, -6'sd10, -6'sd10,  6'sd10,  6'sd20},
    '{-6'sd30, -6'sd20,  6'sd0,   6'sd20,  6'sd30},
    '{-6'sd20, -6'sd10,  6'sd10,  6'sd10,  6'sd20},
    '{ 6'sd20,  6'sd10,  6'sd10, -6'sd10, -6'sd20}
  };

  function automatic err_tab_t err_tab();
    err_tab_t t;
    for (int k = 0; k < ERR_HALF_W; k++) begin
      t[k] = GRADE_W'((ERR_HALF_W - k) * GRADE_ONE / ERR_HALF_W);
    end
    return t;
  endfunction

  function automatic dlt_tab_t dlt_tab();
    dlt_tab_t t;
    for (int k = 0; k < DLT_HALF_W; k++) begin
      t[k] = GRADE_W'((DLT_HALF_W - k) * GRADE_ONE / DLT_HALF_W);
    end
    return t;
  endfunction

  localparam err_tab_t ERR_SLOPE = err_tab();
  localparam dlt_tab_t DLT_SLOPE = dlt_tab();

  function automatic grade_t grade_of(logic signed [V_W-1:0] v,
                                      logic signed [V_W-1:0] c,
                                      logic is_err, shape_e shape);
    logic signed [V_W-1:0] d;
    logic [V_W-1:0] ad;
    logic [V_W-1:0] w;
    grade_t g;
    d  = v - c;
    ad = d[V_W-1] ? V_W'(-d) : V_W'(d);
    w  = is_err ? V_W'(ERR_HALF_W) : V_W'(DLT_HALF_W);
    if (ad >= w) g = '0;
    else if (is_err) g = ERR_SLOPE[ad[5:0]];
    else g = DLT_SLOPE[ad[3:0]];
    if (shape == SHAPE_LEFT && v <= c) g = GRADE_W'(GRADE_ONE);
    if (shape == SHAPE_RIGHT && v >= c) g = GRADE_W'(GRADE_ONE);
    return g;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/flfs_ctrl.sv =====
`default_nettype none
module flfs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output flfs_pkg::cmd_t     cmd_o
);

  flfs_pkg::state_e state_q, state_d;
  logic [flfs_pkg::SET_W-1:0]  ri_q, ri_d, rj_q, rj_d;
  logic [flfs_pkg::DCNT_W-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic rule_end, div_end, out_free;

  assign rule_end = (ri_q == flfs_pkg::SET_W'(flfs_pkg::N_SETS - 1)) &&
                    (rj_q == flfs_pkg::SET_W'(flfs_pkg::N_SETS - 1));
  assign div_end  = (cnt_q == flfs_pkg::DCNT_W'(flfs_pkg::MAG_W - 1));
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      flfs_pkg::ST_IDLE:   if (in_valid_i) state_d = flfs_pkg::ST_FUZZ;
      flfs_pkg::ST_FUZZ:   state_d = flfs_pkg::ST_RULE;
      flfs_pkg::ST_RULE:   if (rule_end) state_d = flfs_pkg::ST_PREP_R;
      flfs_pkg::ST_PREP_R: state_d = flfs_pkg::ST_DIV_R;
      flfs_pkg::ST_DIV_R:  if (div_end) state_d = flfs_pkg::ST_PREP_L;
      flfs_pkg::ST_PREP_L: state_d = flfs_pkg::ST_DIV_L;
      flfs_pkg::ST_DIV_L:  if (div_end) state_d = flfs_pkg::ST_DONE;
      flfs_pkg::ST_DONE:   if (out_free) state_d = flfs_pkg::ST_IDLE;
      default:             state_d = flfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.ri    = ri_q;
    cmd_o.rj    = rj_q;
    in_stall_o  = 1'b1;
    ri_d        = ri_q;
    rj_d        = rj_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      flfs_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      flfs_pkg::ST_FUZZ: begin
        cmd_o.fuzz = 1'b1;
        ri_d = '0;
        rj_d = '0;
      end
      flfs_pkg::ST_RULE: begin
        cmd_o.rule = 1'b1;
        if (rule_end) begin
          rj_d = '0;
          ri_d = '0;
        end else if (rj_q == flfs_pkg::SET_W'(flfs_pkg::N_SETS - 1)) begin
          rj_d = '0;
          ri_d = ri_q + 1'b1;
        end else begin
          rj_d = rj_q + 1'b1;
        end
      end
      flfs_pkg::ST_PREP_R, flfs_pkg::ST_PREP_L: begin
        cmd_o.prep      = 1'b1;
        cmd_o.side_left = (state_q == flfs_pkg::ST_PREP_L);
        cnt_d = '0;
      end
      flfs_pkg::ST_DIV_R, flfs_pkg::ST_DIV_L: begin
        cmd_o.step      = 1'b1;
        cmd_o.last      = div_end;
        cmd_o.side_left = (state_q == flfs_pkg::ST_DIV_L);
        cnt_d = cnt_q + 1'b1;
      end
      flfs_pkg::ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= flfs_pkg::ST_IDLE;
      ri_q        <= '0;
      rj_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ri_q        <= ri_d;
      rj_q        <= rj_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_to_fuzz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == flfs_pkg::ST_FUZZ)
    else $error("accepted beat did not start fuzzification");

  a_valid_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(!out_stall_i))
    else $error("result dropped without being taken");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

// ===== rtl/flfs_dp.sv =====
`default_nettype none
module flfs_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire flfs_pkg::cmd_t                cmd_i,
  input  wire logic [flfs_pkg::SAMPLE_W-1:0] sensor_sample_i,
  input  wire logic [flfs_pkg::SAMPLE_W-1:0] setpoint_i,
  input  wire logic [flfs_pkg::SAMPLE_W-1:0] floor_i,
  input  wire logic [flfs_pkg::SAMPLE_W-1:0] ceiling_i,
  input  wire logic [flfs_pkg::BASE_W-1:0]   rbase_i,
  input  wire logic [flfs_pkg::BASE_W-1:0]   lbase_i,
  output logic signed [flfs_pkg::DRIVE_W-1:0] right_drive_o,
  output logic signed [flfs_pkg::DRIVE_W-1:0] left_drive_o
);

  logic [flfs_pkg::SAMPLE_W-1:0] clamped;
  logic signed [flfs_pkg::ERR_W-1:0] err_new, last_err_q, err_q;
  logic signed [flfs_pkg::DLT_W-1:0] dlt_q;
  flfs_pkg::grade_t ge_q [flfs_pkg::N_SETS];
  flfs_pkg::grade_t gd_q [flfs_pkg::N_SETS];
  flfs_pkg::grade_t s;
  logic signed [flfs_pkg::PROD_W-1:0] prod;
  logic [flfs_pkg::DEN_W-1:0] den_q;
  logic signed [flfs_pkg::NUM_W-1:0] num_q;
  logic [flfs_pkg::BASE_W-1:0] base;
  logic [flfs_pkg::MAG_W-1:0] bd;
  logic signed [flfs_pkg::XW-1:0] x;
  logic [flfs_pkg::MAG_W-1:0] dvd_q, dvd_d;
  logic [flfs_pkg::DEN_W-1:0] rem_q, rem_d;
  logic [flfs_pkg::DEN_W:0] rem_sh;
  logic qbit, neg_q;
  logic [flfs_pkg::BASE_W-1:0] sat;
  logic signed [flfs_pkg::DRIVE_W-1:0] res;
  logic signed [flfs_pkg::DRIVE_W-1:0] res_r_q, res_l_q, out_r_q, out_l_q;

  always_comb begin
    if (sensor_sample_i < floor_i) clamped = floor_i;
    else if (sensor_sample_i > ceiling_i) clamped = ceiling_i;
    else clamped = sensor_sample_i;
    err_new = $signed({1'b0, setpoint_i}) - $signed({1'b0, clamped});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
    end else if (cmd_i.load) begin
      last_err_q <= err_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_q <= err_new;
      dlt_q <= flfs_pkg::DLT_W'(err_new) - flfs_pkg::DLT_W'(last_err_q);
    end
  end

  // grades of both inputs, one table lookup per set
  always_ff @(posedge clk_i) begin
    if (cmd_i.fuzz) begin
      for (int k = 0; k < flfs_pkg::N_SETS; k++) begin
        ge_q[k] <= flfs_pkg::grade_of(flfs_pkg::V_W'(err_q), flfs_pkg::ERR_CENTRE[k], 1'b1,
          k == 0 ? flfs_pkg::SHAPE_LEFT :
          (k == flfs_pkg::N_SETS - 1 ? flfs_pkg::SHAPE_RIGHT : flfs_pkg::SHAPE_MID));
        gd_q[k] <= flfs_pkg::grade_of(flfs_pkg::V_W'(dlt_q), flfs_pkg::DLT_CENTRE[k], 1'b0,
          k == 0 ? flfs_pkg::SHAPE_LEFT :
          (k == flfs_pkg::N_SETS - 1 ? flfs_pkg::SHAPE_RIGHT : flfs_pkg::SHAPE_MID));
      end
    end
  end

  // one rule per cycle
  assign s = (gd_q[cmd_i.ri] < ge_q[cmd_i.rj]) ? gd_q[cmd_i.ri] : ge_q[cmd_i.rj];
  assign prod = $signed({1'b0, s}) * flfs_pkg::SINGLETON[cmd_i.ri][cmd_i.rj];

  always_ff @(posedge clk_i) begin
    if (cmd_i.fuzz) begin
      den_q <= '0;
      num_q <= '0;
    end else if (cmd_i.rule) begin
      den_q <= den_q + flfs_pkg::DEN_W'(s);
      num_q <= num_q + flfs_pkg::NUM_W'(prod);
    end
  end

  // drive = (base*den +/- num) / den, restoring divide on the magnitude
  assign base = cmd_i.side_left ? lbase_i : rbase_i;
  assign bd   = flfs_pkg::MAG_W'(base) * flfs_pkg::MAG_W'(den_q);
  assign x    = cmd_i.side_left ?
                $signed({1'b0, bd}) - flfs_pkg::XW'(num_q) :
                $signed({1'b0, bd}) + flfs_pkg::XW'(num_q);

  always_comb begin
    rem_sh = {rem_q, dvd_q[flfs_pkg::MAG_W-1]};
    qbit   = (rem_sh >= {1'b0, den_q});
    rem_d  = qbit ? flfs_pkg::DEN_W'(rem_sh - {1'b0, den_q})
                  : flfs_pkg::DEN_W'(rem_sh);
    dvd_d  = {dvd_q[flfs_pkg::MAG_W-2:0], qbit};
    if (den_q == '0) begin
      sat = base;
    end else if (|dvd_d[flfs_pkg::MAG_W-1:flfs_pkg::BASE_W]) begin
      sat = flfs_pkg::BASE_W'(flfs_pkg::DRIVE_MAX);
    end else begin
      sat = dvd_d[flfs_pkg::BASE_W-1:0];
    end
    res = (neg_q && den_q != '0) ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      neg_q <= x[flfs_pkg::XW-1];
      dvd_q <= x[flfs_pkg::XW-1] ? flfs_pkg::MAG_W'(-x) : flfs_pkg::MAG_W'(x);
      rem_q <= '0;
    end else if (cmd_i.step) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
    if (cmd_i.step && cmd_i.last) begin
      if (cmd_i.side_left) res_l_q <= res;
      else res_r_q <= res;
    end
    if (cmd_i.out_load) begin
      out_r_q <= res_r_q;
      out_l_q <= res_l_q;
    end
  end

  assign right_drive_o = out_r_q;
  assign left_drive_o  = out_l_q;

endmodule
`default_nettype wire

// ===== rtl/fuzzy_line_follow_steering.sv =====
`default_nettype none
// fuzzy line-follow steering: each sensor beat is clamped to the floor/ceiling
// window, turned into an error against the setpoint and a delta against the
// previous error, fuzzified into five sets each, and run through 25 min rules
// with a fixed singleton table; the weighted average correction is added to
// the right base speed and subtracted from the left one, truncated toward zero
// and saturated to +/-255. an item goes from acceptance through fuzzification,
// the 25 rules in turn through one multiply-accumulate, two passes (setup
// plus 21 bit steps) through a shared restoring divider, one per wheel, and
// a load of the output register. input is taken only when the core is idle;
// a finished result sits in the output register until taken, while the next
// beat is already being worked on. the user must write configuration through
// cfg_we_i/cfg_idx_i/cfg_data_i only while idle; the core does not enforce it.
module fuzzy_line_follow_steering (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [flfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [flfs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [flfs_pkg::SAMPLE_W-1:0]   sensor_sample_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [flfs_pkg::DRIVE_W-1:0]  right_drive_o,
  output logic signed [flfs_pkg::DRIVE_W-1:0]  left_drive_o
);

  flfs_pkg::cmd_t cmd;

  // configuration registers
  logic [flfs_pkg::SAMPLE_W-1:0] setpoint_q, floor_q, ceiling_q;
  logic [flfs_pkg::BASE_W-1:0]   rbase_q, lbase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= 10'd320;
      floor_q    <= 10'd120;
      ceiling_q  <= 10'd500;
      rbase_q    <= 8'd50;
      lbase_q    <= 8'd50;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        flfs_pkg::REG_SETPOINT: setpoint_q <= cfg_data_i;
        flfs_pkg::REG_FLOOR:    floor_q    <= cfg_data_i;
        flfs_pkg::REG_CEILING:  ceiling_q  <= cfg_data_i;
        flfs_pkg::REG_RBASE:    rbase_q    <= cfg_data_i[flfs_pkg::BASE_W-1:0];
        flfs_pkg::REG_LBASE:    lbase_q    <= cfg_data_i[flfs_pkg::BASE_W-1:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // sequencer: fuzzify, rule sweep, two divides, output load
  flfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // error/delta, grades, accumulators, divider and result registers
  flfs_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sensor_sample_i (sensor_sample_i),
    .setpoint_i      (setpoint_q),
    .floor_i         (floor_q),
    .ceiling_i       (ceiling_q),
    .rbase_i         (rbase_q),
    .lbase_i         (lbase_q),
    .right_drive_o   (right_drive_o),
    .left_drive_o    (left_drive_o)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  // drain margin waited after the last expected beat is checked
  localparam int LATENCY = 80;
  localparam int WATCHDOG_LIMIT = 20000;

  // register indexes past the end of the list
  localparam logic [flfs_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [flfs_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [flfs_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [flfs_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [flfs_pkg::SAMPLE_W-1:0] sensor_sample_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [flfs_pkg::DRIVE_W-1:0] right_drive_o;
  logic signed [flfs_pkg::DRIVE_W-1:0] left_drive_o;

  fuzzy_line_follow_steering u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .sensor_sample_i,
    .out_valid_o, .out_stall_i, .right_drive_o, .left_drive_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct packed {
    logic signed [flfs_pkg::DRIVE_W-1:0] right;
    logic signed [flfs_pkg::DRIVE_W-1:0] left;
  } drive_pair_t;

  // predictor copy of the registers and the error history
  int unsigned m_setpoint = 320, m_floor = 120, m_ceiling = 500;
  int unsigned m_rbase = 50, m_lbase = 50;
  int m_last_err = 0;

  drive_pair_t drive_q[$];
  int mismatches = 0;
  int watchdog = 0;
  bit long_hold = 1'b0;

  // singleton table indexed [delta set][error set]
  int rule_out [5][5] = '{
    '{ 20,  10, -10, -10, -20},
    '{-20, -10, -10,  10,  20},
    '{-30, -20,   0,  20,  30},
    '{-20, -10,  10,  10,  20},
    '{ 20,  10,  10, -10, -20}
  };

  function automatic int unsigned membership(int v, int c, int w, int shoulder);
    int d;
    if (shoulder < 0 && v <= c) return flfs_pkg::GRADE_ONE;
    if (shoulder > 0 && v >= c) return flfs_pkg::GRADE_ONE;
    d = (v < c) ? c - v : v - c;
    if (d >= w) return 0;
    return ((w - d) * flfs_pkg::GRADE_ONE) / w;
  endfunction

  function automatic int sat_drive(longint base, longint num, longint den);
    longint v;
    v = (den == 0) ? base : (base * den + num) / den;
    if (v > flfs_pkg::DRIVE_MAX) v = flfs_pkg::DRIVE_MAX;
    if (v < -flfs_pkg::DRIVE_MAX) v = -flfs_pkg::DRIVE_MAX;
    return int'(v);
  endfunction

  // fuzzy pd steering for one sample, advances the error history
  function automatic drive_pair_t steer(int unsigned raw);
    int unsigned s, ge[5], gd[5], st;
    int err, dlt;
    longint num, den;
    drive_pair_t p;
    s = raw;
    if (s < m_floor) s = m_floor;
    else if (s > m_ceiling) s = m_ceiling;
    err = int'(m_setpoint) - int'(s);
    dlt = err - m_last_err;
    for (int k = 0; k < 5; k++) begin
      ge[k] = membership(err, -100 + 50 * k, 50, k == 0 ? -1 : (k == 4 ? 1 : 0));
      gd[k] = membership(dlt, -20 + 10 * k, 10, k == 0 ? -1 : (k == 4 ? 1 : 0));
    end
    num = 0;
    den = 0;
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 5; j++) begin
        st = (gd[i] < ge[j]) ? gd[i] : ge[j];
        den += st;
        num += longint'(st) * rule_out[i][j];
      end
    end
    p.right = flfs_pkg::DRIVE_W'(sat_drive(m_rbase, num, den));
    p.left = flfs_pkg::DRIVE_W'(sat_drive(m_lbase, -num, den));
    m_last_err = err;
    return p;
  endfunction

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  // sender: gap control, one beat, then prediction
  bit send_gaps = 1'b1;

  task automatic send_sample(int unsigned v);
    int g;
    g = send_gaps ? short_gap() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sensor_sample_i <= flfs_pkg::SAMPLE_W'(v);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    drive_q.push_back(steer(v));
    @(negedge clk_i);
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (drive_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [flfs_pkg::CFG_IDX_W-1:0] idx, int unsigned v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= flfs_pkg::CFG_DATA_W'(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      flfs_pkg::REG_SETPOINT: m_setpoint = v & 10'h3FF;
      flfs_pkg::REG_FLOOR: m_floor = v & 10'h3FF;
      flfs_pkg::REG_CEILING: m_ceiling = v & 10'h3FF;
      flfs_pkg::REG_RBASE: m_rbase = v & 8'hFF;
      flfs_pkg::REG_LBASE: m_lbase = v & 8'hFF;
      default: ;
    endcase
  endtask

  task automatic set_all(int unsigned sp, int unsigned fl, int unsigned ce,
                         int unsigned rb, int unsigned lb);
    write_reg(flfs_pkg::REG_SETPOINT, sp);
    write_reg(flfs_pkg::REG_FLOOR, fl);
    write_reg(flfs_pkg::REG_CEILING, ce);
    write_reg(flfs_pkg::REG_RBASE, rb);
    write_reg(flfs_pkg::REG_LBASE, lb);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (long_hold) out_stall_i <= 1'b1;
    else if ($urandom_range(0, 3) == 0) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(0, 30) == 0);
  end

  // checker and watchdog at the rising edge
  always @(posedge clk_i) begin
    drive_pair_t exp_p;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (out_valid_o && !out_stall_i) begin
        if (drive_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat r=%0d l=%0d",
                                         right_drive_o, left_drive_o);
        end else begin
          exp_p = drive_q.pop_front();
          if (exp_p.right !== right_drive_o || exp_p.left !== left_drive_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("drive mismatch: exp r=%0d l=%0d got r=%0d l=%0d",
                       exp_p.right, exp_p.left, right_drive_o, left_drive_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    int unsigned pts[8] = '{0, 119, 120, 320, 500, 501, 1023, 320};
    foreach (pts[k]) send_sample(pts[k]);
    end_burst();
    drain();
  endtask

  task automatic test_directed_extremes();
    // drive saturation both ways, error and delta shoulders
    set_all(1023, 0, 1023, 255, 255);
    send_sample(0);
    send_sample(1023);
    send_sample(0);
    send_sample(1000);
    send_sample(1010);
    end_burst();
    drain();
    set_all(0, 0, 1023, 0, 0);
    send_sample(1023);
    send_sample(0);
    send_sample(50);
    send_sample(100);
    send_sample(60);
    end_burst();
    drain();
    // floor above the ceiling
    set_all(512, 700, 300, 128, 77);
    send_sample(100);
    send_sample(500);
    send_sample(900);
    end_burst();
    drain();
    // unused register index is ignored
    write_reg(REG_SPARE_HI, 10'h3FF);
    write_reg(REG_SPARE_LO, 10'h155);
    send_sample(512);
    end_burst();
    drain();
  endtask

  task automatic test_random_phases();
    int unsigned v, prev;
    for (int ph = 0; ph < 12; ph++) begin
      set_all($urandom_range(0, 1023), $urandom_range(0, 400),
              $urandom_range(300, 1023), $urandom_range(0, 255), $urandom_range(0, 255));
      send_gaps = (ph % 3 != 2);
      prev = $urandom_range(0, 1023);
      for (int n = 0; n < 150; n++) begin
        // mostly small walks around the previous reading, some wild ones
        if ($urandom_range(0, 4) == 0) v = $urandom_range(0, 1023);
        else v = (prev + $urandom_range(0, 40) + 1004) % 1024;
        send_sample(v);
        prev = v;
      end
      end_burst();
      drain();
    end
    send_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    set_all(320, 120, 500, 50, 50);
    long_hold = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk_i);
        long_hold = 1'b0;
      end
      begin
        send_gaps = 1'b0;
        for (int n = 0; n < 10; n++) send_sample($urandom_range(0, 1023));
        end_burst();
        send_gaps = 1'b1;
      end
    join
    drain();
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_directed_extremes();
    test_random_phases();
    test_backpressure();
    if (mismatches == 0 && drive_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== fuzzy_line_follow_steering.f =====
rtl/flfs_pkg.sv
rtl/flfs_ctrl.sv
rtl/flfs_dp.sv
rtl/fuzzy_line_follow_steering.sv
tb/tb_top.sv
